@@ rtl/core/rf_power_swr_monitor_macros.svh @@
// Assertion macros for the RF power and SWR monitor.
`ifndef RF_POWER_SWR_MONITOR_MACROS_SVH
`define RF_POWER_SWR_MONITOR_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define RPSM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define RPSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/rpsm_pkg.sv @@
// Types and constants of the RF power and SWR monitor.
package rpsm_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int POWER_BITS  = 13;
    localparam int SWR_BITS    = 10;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int S_TDATA_BITS  = 16;
    localparam int S_TUSER_BITS  = 2;
    localparam int M_TDATA_BITS  = 40;

    localparam logic [20:0] POWER_DIV = 21'd1000000;
    localparam logic [9:0]  SWR_CAP   = 10'd999;
    localparam logic [9:0]  SWR_NONE  = 10'd100;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DPREP,
        S_DIV,
        S_SWRP,
        S_SWRDIV,
        S_UPD
    } t_state;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_POWER_GAIN,
        REG_MIN_FORWARD,
        REG_REFLECT_MARGIN,
        REG_HOLD_TICKS,
        REG_LATCH_TICKS,
        REG_DECAY_PERIOD,
        REG_HIGH_ALARM_SWR,
        REG_LOW_ALARM_SWR
    } t_reg_idx;

endpackage

@@ rtl/core/rf_power_swr_monitor.sv @@
// RF power and SWR monitor: serial power conversion, peak hold, SWR and alarms.
// Each item is one sample tick; one result item follows every accepted item.
// Forward and then reflected readings are converted to watts each by a
// bit-serial shift-add multiplier, a setup step and a restoring divider.
// One step then checks carrier and margin; the same divider forms the SWR
// quotient bit by bit (skipped without a computed SWR), and a final step
// updates peak, hold, decay and alarm state. That last step waits while
// the previous result is still held in the output register. Input is taken
// only while no item is in work, so s_axis_tready rises again only as the
// result becomes valid; a finished result waits in the output register
// while the next item is accepted and processed.
module rf_power_swr_monitor (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // forward_sample [7:0], reflected_sample [15:8]
    input  logic [rpsm_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
    // net_mode [0], realtime_mode [1]
    input  logic [rpsm_pkg::S_TUSER_BITS-1:0]    s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // active_power [12:0], shown_power [25:13], swr_hundredths [35:26],
    // carrier_present [36], high_alarm [37], low_alarm [38], zero [39]
    output logic [rpsm_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rpsm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [rpsm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import rpsm_pkg::*;
    `include "rf_power_swr_monitor_macros.svh"

    // configuration
    logic [15:0] r_gain;
    logic [7:0]  r_min_fwd, r_margin;
    logic [9:0]  r_hold_ticks, r_latch_ticks, r_hi_thr, r_lo_thr;
    logic [3:0]  r_decay_per;

    // control and datapath
    t_state      r_state, n_state;
    logic        r_sel, n_sel;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_sq, n_sq;
    logic [31:0] r_acc, n_acc;
    logic [20:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [7:0]  r_fwd, n_fwd, r_ref, n_ref, r_dsr, n_dsr;
    logic        r_net, n_net, r_rt, n_rt;
    logic [12:0] r_fp, n_fp, r_rp, n_rp;
    logic [9:0]  r_swr, n_swr;
    logic        r_carrier, n_carrier;

    // tick state
    logic [12:0] r_peak, n_peak;
    logic [9:0]  r_hold, n_hold, r_hi_cnt, n_hi_cnt, r_lo_cnt, n_lo_cnt;
    logic [3:0]  r_dcnt, n_dcnt;
    logic        r_hi_flag, n_hi_flag, r_lo_flag, n_lo_flag;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [M_TDATA_BITS-1:0] r_odata, n_odata;

    logic        s_acc;
    logic [20:0] d_t, d_dv;
    logic        d_ge;
    logic [9:0]  w_rm;
    logic [8:0]  w_sum;
    logic [15:0] w_num;
    logic [12:0] u_act, u_peak, u_step;
    logic [9:0]  u_hold;
    logic [3:0]  u_dcnt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= 16'd38446;
            r_min_fwd     <= 8'd5;
            r_margin      <= 8'd2;
            r_hold_ticks  <= 10'd200;
            r_latch_ticks <= 10'd600;
            r_decay_per   <= 4'd3;
            r_hi_thr      <= 10'd300;
            r_lo_thr      <= 10'd200;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_POWER_GAIN:     r_gain        <= i_cfg_data;
                REG_MIN_FORWARD:    r_min_fwd     <= i_cfg_data[7:0];
                REG_REFLECT_MARGIN: r_margin      <= i_cfg_data[7:0];
                REG_HOLD_TICKS:     r_hold_ticks  <= i_cfg_data[9:0];
                REG_LATCH_TICKS:    r_latch_ticks <= i_cfg_data[9:0];
                REG_DECAY_PERIOD:   r_decay_per   <= i_cfg_data[3:0];
                REG_HIGH_ALARM_SWR: r_hi_thr      <= i_cfg_data[9:0];
                REG_LOW_ALARM_SWR:  r_lo_thr      <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_peak    <= '0;
            r_hold    <= '0;
            r_dcnt    <= '0;
            r_hi_cnt  <= '0;
            r_lo_cnt  <= '0;
            r_hi_flag <= 1'b0;
            r_lo_flag <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ovalid  <= n_ovalid;
            r_peak    <= n_peak;
            r_hold    <= n_hold;
            r_dcnt    <= n_dcnt;
            r_hi_cnt  <= n_hi_cnt;
            r_lo_cnt  <= n_lo_cnt;
            r_hi_flag <= n_hi_flag;
            r_lo_flag <= n_lo_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel     <= n_sel;
        r_cnt     <= n_cnt;
        r_sq      <= n_sq;
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_fwd     <= n_fwd;
        r_ref     <= n_ref;
        r_dsr     <= n_dsr;
        r_net     <= n_net;
        r_rt      <= n_rt;
        r_fp      <= n_fp;
        r_rp      <= n_rp;
        r_swr     <= n_swr;
        r_carrier <= n_carrier;
        r_odata   <= n_odata;
    end

    // shared restoring divider step, one quotient bit per cycle
    always_comb begin
        d_t  = {r_rem[19:0], r_acc[31]};
        d_dv = (r_state == S_SWRDIV) ? {13'd0, r_dsr} : POWER_DIV;
        d_ge = (d_t >= d_dv);
    end

    always_comb begin
        w_rm  = {2'd0, r_ref} + {2'd0, r_margin};
        w_sum = {1'b0, r_fwd} + {1'b0, r_ref};
        w_num = {1'b0, w_sum, 6'd0} + {2'b0, w_sum, 5'd0} + {5'd0, w_sum, 2'd0};
    end

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_cnt     = r_cnt;
        n_sq      = r_sq;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_fwd     = r_fwd;
        n_ref     = r_ref;
        n_dsr     = r_dsr;
        n_net     = r_net;
        n_rt      = r_rt;
        n_fp      = r_fp;
        n_rp      = r_rp;
        n_swr     = r_swr;
        n_carrier = r_carrier;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;
        n_peak    = r_peak;
        n_hold    = r_hold;
        n_dcnt    = r_dcnt;
        n_hi_cnt  = r_hi_cnt;
        n_lo_cnt  = r_lo_cnt;
        n_hi_flag = r_hi_flag;
        n_lo_flag = r_lo_flag;
        u_act     = '0;
        u_peak    = '0;
        u_step    = '0;
        u_hold    = '0;
        u_dcnt    = '0;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_fwd   = s_axis_tdata[7:0];
                    n_ref   = s_axis_tdata[15:8];
                    n_net   = s_axis_tuser[0];
                    n_rt    = s_axis_tuser[1];
                    n_sq    = {8'd0, s_axis_tdata[7:0]} * {8'd0, s_axis_tdata[7:0]};
                    n_sel   = 1'b0;
                    n_acc   = '0;
                    n_cnt   = 4'd15;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = {r_acc[30:0], 1'b0} + (r_gain[r_cnt] ? {16'd0, r_sq} : 32'd0);
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_state = S_DPREP;
                end
            end
            S_DPREP: begin
                // product < 2^32 and quotient < 2^13, so the top 19 bits start below the divisor
                n_rem   = {2'd0, r_acc[31:13]};
                n_acc   = {r_acc[12:0], 19'd0};
                n_quo   = '0;
                n_cnt   = 4'd12;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem = d_ge ? (d_t - d_dv) : d_t;
                n_acc = {r_acc[30:0], 1'b0};
                n_quo = {r_quo[14:0], d_ge};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    if (!r_sel) begin
                        n_fp    = n_quo[12:0];
                        n_sel   = 1'b1;
                        n_sq    = {8'd0, r_ref} * {8'd0, r_ref};
                        n_acc   = '0;
                        n_cnt   = 4'd15;
                        n_state = S_MUL;
                    end else begin
                        n_rp    = n_quo[12:0];
                        n_state = S_SWRP;
                    end
                end
            end
            S_SWRP: begin
                n_carrier = (r_fwd >= r_min_fwd);
                if (n_carrier && ({2'd0, r_fwd} > w_rm)) begin
                    n_dsr   = r_fwd - r_ref;
                    n_acc   = {w_num, 16'd0};
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = 4'd15;
                    n_state = S_SWRDIV;
                end else begin
                    n_swr   = n_carrier ? SWR_CAP : SWR_NONE;
                    n_state = S_UPD;
                end
            end
            S_SWRDIV: begin
                n_rem = d_ge ? (d_t - d_dv) : d_t;
                n_acc = {r_acc[30:0], 1'b0};
                n_quo = {r_quo[14:0], d_ge};
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_swr   = (n_quo > {6'd0, SWR_CAP}) ? SWR_CAP : n_quo[9:0];
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (!r_ovalid || m_axis_tready) begin
                    u_act = r_net ? ((r_fp > r_rp) ? (r_fp - r_rp) : 13'd0) : r_fp;
                    u_peak = r_peak;
                    u_hold = r_hold;
                    if (u_act >= r_peak) begin
                        u_peak = u_act;
                        u_hold = r_hold_ticks;
                    end
                    if (r_carrier) begin
                        if (r_swr >= r_hi_thr) begin
                            n_hi_flag = 1'b1;
                            n_hi_cnt  = r_latch_ticks;
                        end
                        if (r_swr >= r_lo_thr) begin
                            n_lo_flag = 1'b1;
                            n_lo_cnt  = r_latch_ticks;
                        end
                    end
                    if (u_hold != 10'd0) begin
                        n_hold = u_hold - 10'd1;
                    end else begin
                        n_hold = u_hold;
                        u_dcnt = r_dcnt + 4'd1;
                        if (u_dcnt >= r_decay_per) begin
                            u_dcnt = '0;
                            if (u_peak > u_act) begin
                                u_step = (u_peak - u_act) >> 3;
                                if (u_step == 13'd0) begin
                                    u_step = 13'd1;
                                end
                                u_peak = u_peak - u_step;
                            end else begin
                                u_peak = u_act;
                            end
                        end
                        n_dcnt = u_dcnt;
                    end
                    n_peak = u_peak;
                    if (n_hi_cnt != 10'd0) begin
                        n_hi_cnt = n_hi_cnt - 10'd1;
                    end else if (!r_carrier || r_swr < r_hi_thr) begin
                        n_hi_flag = 1'b0;
                    end
                    if (n_lo_cnt != 10'd0) begin
                        n_lo_cnt = n_lo_cnt - 10'd1;
                    end else if (!r_carrier || r_swr < r_lo_thr) begin
                        n_lo_flag = 1'b0;
                    end
                    n_odata  = {1'b0, n_lo_flag, n_hi_flag, r_carrier, r_swr,
                                (r_rt ? u_act : u_peak), u_act};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `RPSM_ASSERT_NEXT(a_accept_starts_mul, s_acc, r_state == S_MUL)
    `RPSM_ASSERT_SAME(a_swr_range, r_ovalid, (r_odata[35:26] >= SWR_NONE) && (r_odata[35:26] <= SWR_CAP))
    `RPSM_ASSERT_SAME(a_no_carrier_swr, r_ovalid && !r_odata[36], r_odata[35:26] == SWR_NONE)

endmodule

@@ tb/rf_power_swr_monitor_tb.sv @@
// Self-checking testbench of the RF power and SWR monitor: directed table, then random phases.
module rf_power_swr_monitor_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rpsm_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RAND_ITEMS   = 240;

    typedef struct packed {
        logic                  low_alarm;
        logic                  high_alarm;
        logic                  carrier;
        logic [SWR_BITS-1:0]   swr;
        logic [POWER_BITS-1:0] shown;
        logic [POWER_BITS-1:0] active;
    } meter_t;

    typedef struct {
        logic [7:0] fwd;
        logic [7:0] rfl;
        logic       net;
        logic       rt;
        logic       typed;
        meter_t     want;
    } row_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_BITS-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_BITS-1:0]  s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_axis_tdata;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // predictor copy of configuration and state
    logic [15:0] cg_gain;
    logic [7:0]  cg_min_fwd, cg_margin;
    logic [9:0]  cg_hold, cg_latch, cg_hi_thr, cg_lo_thr;
    logic [3:0]  cg_decay;
    logic [12:0] pk_power;
    logic [9:0]  pk_hold, hi_cnt, lo_cnt;
    logic [3:0]  pk_decay;
    logic        hi_flag, lo_flag;

    meter_t readings_due[$];
    int     cycles = 0;
    int     mismatches = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     burst_left = 0;

    rf_power_swr_monitor i_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [12:0] to_watts(logic [7:0] s);
        logic [63:0] p;
        p = 64'(s) * 64'(s) * 64'(cg_gain) / 64'd1000000;
        return (p > 64'd8191) ? 13'd8191 : p[12:0];
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic cfg_reset_model();
        cg_gain = 16'd38446; cg_min_fwd = 8'd5; cg_margin = 8'd2; cg_hold = 10'd200;
        cg_latch = 10'd600; cg_decay = 4'd3; cg_hi_thr = 10'd300; cg_lo_thr = 10'd200;
        pk_power = '0; pk_hold = '0; pk_decay = '0;
        hi_cnt = '0; lo_cnt = '0; hi_flag = 1'b0; lo_flag = 1'b0;
    endtask

    task automatic meter_tick(input logic [7:0] fwd, input logic [7:0] rfl,
                              input logic net, input logic rt, output meter_t r);
        logic [12:0] fp, rp, act;
        logic        carrier;
        int          swr, f, b;
        fp = to_watts(fwd);
        rp = to_watts(rfl);
        act = net ? ((fp > rp) ? fp - rp : 13'd0) : fp;
        if (act >= pk_power) begin
            pk_power = act;
            pk_hold = cg_hold;
        end
        carrier = fwd >= cg_min_fwd;
        f = int'(fwd);
        b = int'(rfl);
        swr = 100;
        if (carrier) begin
            if (f > b + int'(cg_margin)) begin
                swr = 100 * (f + b) / (f - b);
                if (swr > 999) swr = 999;
            end else begin
                swr = 999;
            end
            if (swr >= int'(cg_hi_thr)) begin
                hi_flag = 1'b1;
                hi_cnt = cg_latch;
            end
            if (swr >= int'(cg_lo_thr)) begin
                lo_flag = 1'b1;
                lo_cnt = cg_latch;
            end
        end
        if (pk_hold > 0) begin
            pk_hold--;
        end else begin
            pk_decay = pk_decay + 4'd1;
            if (pk_decay >= cg_decay) begin
                pk_decay = '0;
                if (pk_power > act) begin
                    fp = (pk_power - act) >> 3;
                    if (fp == 0) fp = 13'd1;
                    pk_power -= fp;
                end else begin
                    pk_power = act;
                end
            end
        end
        if (hi_cnt > 0) hi_cnt--;
        else if (!carrier || swr < int'(cg_hi_thr)) hi_flag = 1'b0;
        if (lo_cnt > 0) lo_cnt--;
        else if (!carrier || swr < int'(cg_lo_thr)) lo_flag = 1'b0;
        r.active = act;
        r.shown = rt ? act : pk_power;
        r.swr = swr[9:0];
        r.carrier = carrier;
        r.high_alarm = hi_flag;
        r.low_alarm = lo_flag;
    endtask

    task automatic send_tick(input logic [7:0] fwd, input logic [7:0] rfl, input logic net,
                             input logic rt, input logic typed, input meter_t want);
        meter_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rfl, fwd};
        s_axis_tuser <= {rt, net};
        do @(posedge i_clk); while (!s_axis_tready);
        meter_tick(fwd, rfl, net, rt, r);
        readings_due.push_back(typed ? want : r);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 4))
                @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        s_axis_tvalid <= 1'b0;
        while (readings_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_POWER_GAIN:     cg_gain = value;
            REG_MIN_FORWARD:    cg_min_fwd = value[7:0];
            REG_REFLECT_MARGIN: cg_margin = value[7:0];
            REG_HOLD_TICKS:     cg_hold = value[9:0];
            REG_LATCH_TICKS:    cg_latch = value[9:0];
            REG_DECAY_PERIOD:   cg_decay = value[3:0];
            REG_HIGH_ALARM_SWR: cg_hi_thr = value[9:0];
            REG_LOW_ALARM_SWR:  cg_lo_thr = value[9:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [15:0] gain, input logic [15:0] minf,
                                input logic [15:0] marg, input logic [15:0] hold,
                                input logic [15:0] latch, input logic [15:0] decay,
                                input logic [15:0] hi, input logic [15:0] lo);
        write_reg(REG_POWER_GAIN, gain);
        write_reg(REG_MIN_FORWARD, minf);
        write_reg(REG_REFLECT_MARGIN, marg);
        write_reg(REG_HOLD_TICKS, hold);
        write_reg(REG_LATCH_TICKS, latch);
        write_reg(REG_DECAY_PERIOD, decay);
        write_reg(REG_HIGH_ALARM_SWR, hi);
        write_reg(REG_LOW_ALARM_SWR, lo);
    endtask

    task automatic random_ticks(input int n);
        logic [7:0] f, b;
        int         kind;
        int         level;
        level = $urandom_range(0, 255);
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                // slowly moving carrier so that peaks hold and decay
                level = level + $urandom_range(0, 40) - 20;
                if (level < 0) level = 0;
                if (level > 255) level = 255;
                if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 255);
                f = 8'(level);
                b = 8'(f >> $urandom_range(1, 4));
            end else if (kind < 6) begin
                f = 8'($urandom_range(0, 255));
                b = (f > 8'd3) ? 8'(f - $urandom_range(0, 3)) : f;
            end else if (kind < 7) begin
                f = 8'($urandom_range(0, 8));
                b = 8'($urandom);
            end else begin
                f = 8'($urandom);
                b = 8'($urandom);
            end
            send_tick(f, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0), 1'b0,
                      '0);
        end
    endtask

    always @(posedge i_clk) begin
        meter_t got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[38:0];
            if (readings_due.size() == 0) begin
                report("unexpected item", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = readings_due.pop_front();
                if (got.active !== want.active) report("active_power", got.active, want.active);
                if (got.shown !== want.shown) report("shown_power", got.shown, want.shown);
                if (got.swr !== want.swr) report("swr_hundredths", got.swr, want.swr);
                if (got.carrier !== want.carrier) report("carrier", got.carrier, want.carrier);
                if (got.high_alarm !== want.high_alarm)
                    report("high_alarm", got.high_alarm, want.high_alarm);
                if (got.low_alarm !== want.low_alarm)
                    report("low_alarm", got.low_alarm, want.low_alarm);
                if (m_axis_tdata[39] !== 1'b0) report("pad bit", {31'd0, m_axis_tdata[39]}, 32'd0);
            end
            results_seen++;
        end
        if (cycles[10]) m_axis_tready <= 1'b1;
        else if (cycles[9]) m_axis_tready <= ($urandom_range(0, 7) == 0);
        else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    row_t rows[$];

    initial begin
        rows = '{
            '{8'd0,   8'd0,   1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 10'd100, 13'd0, 13'd0}},
            '{8'd255, 8'd0,   1'b0, 1'b0, 1'b1,
              '{1'b0, 1'b0, 1'b1, 10'd100, 13'd2499, 13'd2499}},
            '{8'd255, 8'd255, 1'b1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 10'd999, 13'd0, 13'd0}},
            '{8'd4,   8'd200, 1'b0, 1'b0, 1'b0, '0},
            '{8'd5,   8'd3,   1'b0, 1'b1, 1'b0, '0},
            '{8'd5,   8'd2,   1'b1, 1'b0, 1'b0, '0},
            '{8'd8,   8'd5,   1'b0, 1'b0, 1'b0, '0},
            '{8'd100, 8'd50,  1'b1, 1'b1, 1'b0, '0},
            '{8'd200, 8'd100, 1'b1, 1'b0, 1'b0, '0},
            '{8'd170, 8'd85,  1'b0, 1'b1, 1'b0, '0},
            '{8'd255, 8'd254, 1'b0, 1'b0, 1'b0, '0},
            '{8'd6,   8'd0,   1'b0, 1'b0, 1'b0, '0},
            '{8'd0,   8'd255, 1'b1, 1'b0, 1'b0, '0},
            '{8'd128, 8'd127, 1'b1, 1'b1, 1'b0, '0},
            '{8'd240, 8'd15,  1'b0, 1'b0, 1'b0, '0},
            '{8'd50,  8'd10,  1'b0, 1'b0, 1'b0, '0}
        };
        cfg_reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[n])
            send_tick(rows[n].fwd, rows[n].rfl, rows[n].net, rows[n].rt, rows[n].typed,
                      rows[n].want);
        random_ticks(RAND_ITEMS);
        load_setting(16'd38446, 16'd5, 16'd2, 16'd3, 16'd5, 16'd1, 16'd300, 16'd200);
        random_ticks(RAND_ITEMS);
        load_setting(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd100, 16'd999);
        random_ticks(RAND_ITEMS);
        load_setting(16'd0, 16'd255, 16'd255, 16'd1023, 16'd1023, 16'd15, 16'd999, 16'd100);
        random_ticks(RAND_ITEMS / 2);
        load_setting(16'd1000, 16'd20, 16'd5, 16'd10, 16'd20, 16'd2, 16'd1023, 16'd0);
        random_ticks(RAND_ITEMS);
        load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        random_ticks(RAND_ITEMS / 2);
        load_setting(16'($urandom), 16'($urandom_range(0, 30)), 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 40)), 16'($urandom_range(0, 60)),
                     16'($urandom_range(0, 15)), 16'($urandom_range(100, 999)),
                     16'($urandom_range(100, 999)));
        random_ticks(RAND_ITEMS);
        s_axis_tvalid <= 1'b0;
        while (readings_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d sample ticks sent, %0d results checked over 7 register settings",
                 items_sent, results_seen);
        $display("%0d mismatches, %0d cycles", mismatches, cycles);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
